// ----- src/rbp_pkg.sv -----
`timescale 1ns / 1ps

package rbp_pkg;

    localparam int ID_W    = 6;
    localparam int CNT_W   = 8;
    localparam int LEN_W   = 15;
    localparam int REQ_W   = 16;
    localparam int DEPTH_W = 7;

    localparam logic [DEPTH_W-1:0] POOL_SIZE   = 7'd64;
    localparam logic [LEN_W-1:0]   CAP_LIMIT   = 15'd16384;
    localparam logic [LEN_W-1:0]   CAP_DEFAULT = 15'd2048;
    localparam logic [CNT_W-1:0]   REF_MAX     = 8'd255;

    localparam logic [2:0] OP_ACQUIRE = 3'd0;
    localparam logic [2:0] OP_ADDREF  = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_SETLEN  = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_HELD  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    typedef struct packed {
        logic [2:0]       operation;
        logic [ID_W-1:0]  buffer_id;
        logic [REQ_W-1:0] length_request;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    result_id;
        logic [CNT_W-1:0]   use_count;
        logic [LEN_W-1:0]   data_length;
        logic [DEPTH_W-1:0] free_count;
        logic               returned_to_pool;
    } rsp_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_sts_t;

endpackage

// ----- src/refcounted_buffer_pool.sv -----
// an accepted item's request and its table and stack reads are registered;
// the result is registered from them, held back only while the previous
// result is still stalled; items are taken one at a time, a new one only
// after the registered table and stack reads and the read-modify-write step
// reset: all 64 buffers free (stack entry i holds buffer i), counts and
// lengths zero through per-entry valid flags, capacity 2048; ready at once
`timescale 1ns / 1ps

module refcounted_buffer_pool (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  rbp_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output rbp_pkg::rsp_t             rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [rbp_pkg::LEN_W-1:0] cfg_data
);

    rbp_pkg::ctrl_cmd_t cmd;
    rbp_pkg::dp_sts_t   sts;

    assign cfg_ready = 1'b1;

    rbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rbp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ----- src/rbp_ctrl.sv -----
`timescale 1ns / 1ps

module rbp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  rbp_pkg::dp_sts_t   sts,
    output rbp_pkg::ctrl_cmd_t cmd
);

    rbp_pkg::state_t state_reg;
    rbp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rbp_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = rbp_pkg::S_EXEC;
                end
            end
            rbp_pkg::S_EXEC:
            begin
                if (!sts.out_busy)
                begin
                    state_next = rbp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rbp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            rbp_pkg::S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            rbp_pkg::S_EXEC:
            begin
                cmd.execute = !sts.out_busy;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/rbp_dp.sv -----
`timescale 1ns / 1ps

module rbp_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rbp_pkg::req_t                    req,
    input  logic                             cfg_we,
    input  logic [rbp_pkg::LEN_W-1:0]        cfg_data,
    input  rbp_pkg::ctrl_cmd_t               cmd,
    output rbp_pkg::dp_sts_t                 sts,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output rbp_pkg::rsp_t                    rsp
);

    localparam int NB = 64;

    logic [rbp_pkg::ID_W-1:0]  stk_mem [NB];
    logic [rbp_pkg::CNT_W-1:0] cnt_mem [NB];
    logic [rbp_pkg::LEN_W-1:0] len_mem [NB];

    logic [NB-1:0] stk_vld_reg;
    logic [NB-1:0] cnt_vld_reg;
    logic [NB-1:0] len_vld_reg;

    logic [rbp_pkg::DEPTH_W-1:0] depth_reg;
    logic [rbp_pkg::DEPTH_W-1:0] depth_next;
    logic [rbp_pkg::LEN_W-1:0]   cap_reg;
    logic                        out_vld_reg;
    rbp_pkg::rsp_t               out_reg;

    logic [2:0]                  op_reg;
    logic [rbp_pkg::ID_W-1:0]    id_reg;
    logic [rbp_pkg::REQ_W-1:0]   rlen_reg;
    logic [rbp_pkg::ID_W-1:0]    stk_rd_reg;
    logic [rbp_pkg::CNT_W-1:0]   cnt_rd_reg;
    logic [rbp_pkg::LEN_W-1:0]   len_rd_reg;

    logic [rbp_pkg::ID_W-1:0]    top_idx;
    logic [rbp_pkg::ID_W-1:0]    top_buf;
    logic [rbp_pkg::CNT_W-1:0]   cnt_cur;
    logic [rbp_pkg::LEN_W-1:0]   len_cur;
    logic [rbp_pkg::LEN_W-1:0]   cap_eff;
    logic [rbp_pkg::LEN_W-1:0]   len_clip;

    logic                        stk_we;
    logic [rbp_pkg::ID_W-1:0]    stk_wa;
    logic [rbp_pkg::ID_W-1:0]    stk_wd;
    logic                        cnt_we;
    logic [rbp_pkg::ID_W-1:0]    cnt_wa;
    logic [rbp_pkg::CNT_W-1:0]   cnt_wd;
    logic                        len_we;
    logic [rbp_pkg::ID_W-1:0]    len_wa;
    logic [rbp_pkg::LEN_W-1:0]   len_wd;
    logic [rbp_pkg::CNT_W-1:0]   cnt_dec;
    rbp_pkg::rsp_t               res;

    assign top_idx = depth_reg[rbp_pkg::ID_W-1:0] - 6'd1;
    assign top_buf = stk_vld_reg[top_idx] ? stk_rd_reg : top_idx;
    assign cnt_cur = cnt_vld_reg[id_reg] ? cnt_rd_reg : '0;
    assign len_cur = len_vld_reg[id_reg] ? len_rd_reg : '0;
    assign cnt_dec = cnt_cur - 8'd1;

    assign cap_eff  = (cap_reg == '0 || cap_reg > rbp_pkg::CAP_LIMIT)
                    ? rbp_pkg::CAP_DEFAULT : cap_reg;
    assign len_clip = ({1'b0, cap_eff} < rlen_reg) ? cap_eff
                                                   : rlen_reg[rbp_pkg::LEN_W-1:0];

    assign sts.out_busy = out_vld_reg && !rsp_ready;
    assign rsp_valid    = out_vld_reg;
    assign rsp          = out_reg;

    always_comb
    begin
        depth_next           = depth_reg;
        stk_we               = 1'b0;
        stk_wa               = depth_reg[rbp_pkg::ID_W-1:0];
        stk_wd               = id_reg;
        cnt_we               = 1'b0;
        cnt_wa               = id_reg;
        cnt_wd               = cnt_cur;
        len_we               = 1'b0;
        len_wa               = id_reg;
        len_wd               = len_clip;
        res.status           = rbp_pkg::ST_OK;
        res.result_id        = id_reg;
        res.use_count        = cnt_cur;
        res.data_length      = len_cur;
        res.returned_to_pool = 1'b0;
        unique case (op_reg)
            rbp_pkg::OP_ACQUIRE:
            begin
                if (depth_reg == '0)
                begin
                    res.status      = rbp_pkg::ST_EMPTY;
                    res.result_id   = '0;
                    res.use_count   = '0;
                    res.data_length = '0;
                end
                else
                begin
                    depth_next      = depth_reg - 7'd1;
                    cnt_we          = 1'b1;
                    cnt_wa          = top_buf;
                    cnt_wd          = 8'd1;
                    len_we          = 1'b1;
                    len_wa          = top_buf;
                    len_wd          = '0;
                    res.result_id   = top_buf;
                    res.use_count   = 8'd1;
                    res.data_length = '0;
                end
            end
            rbp_pkg::OP_ADDREF:
            begin
                cnt_we        = 1'b1;
                cnt_wd        = (cnt_cur == rbp_pkg::REF_MAX) ? cnt_cur : cnt_cur + 8'd1;
                res.use_count = cnt_wd;
            end
            rbp_pkg::OP_RELEASE:
            begin
                if (cnt_cur == '0)
                begin
                    res.status = rbp_pkg::ST_ZERO;
                end
                else
                begin
                    cnt_we        = 1'b1;
                    cnt_wd        = cnt_dec;
                    res.use_count = cnt_dec;
                    if (cnt_dec != '0)
                    begin
                        res.status = rbp_pkg::ST_HELD;
                    end
                    else if (depth_reg < rbp_pkg::POOL_SIZE)
                    begin
                        stk_we               = 1'b1;
                        depth_next           = depth_reg + 7'd1;
                        res.returned_to_pool = 1'b1;
                    end
                end
            end
            rbp_pkg::OP_SETLEN:
            begin
                len_we          = 1'b1;
                res.data_length = len_clip;
            end
            default:
            begin
                res.status = rbp_pkg::ST_OK;
            end
        endcase
        res.free_count = depth_next;
    end

    // payload and memories
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= req.operation;
            id_reg     <= req.buffer_id;
            rlen_reg   <= req.length_request;
            cnt_rd_reg <= cnt_mem[req.buffer_id];
            len_rd_reg <= len_mem[req.buffer_id];
            stk_rd_reg <= stk_mem[depth_reg[rbp_pkg::ID_W-1:0] - 6'd1];
        end
        if (cmd.execute && stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (cmd.execute && cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cmd.execute && len_we)
        begin
            len_mem[len_wa] <= len_wd;
        end
        if (cmd.execute)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stk_vld_reg <= '0;
            cnt_vld_reg <= '0;
            len_vld_reg <= '0;
            depth_reg   <= rbp_pkg::POOL_SIZE;
            cap_reg     <= rbp_pkg::CAP_DEFAULT;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.execute)
            begin
                depth_reg   <= depth_next;
                out_vld_reg <= 1'b1;
                if (stk_we)
                begin
                    stk_vld_reg[stk_wa] <= 1'b1;
                end
                if (cnt_we)
                begin
                    cnt_vld_reg[cnt_wa] <= 1'b1;
                end
                if (len_we)
                begin
                    len_vld_reg[len_wa] <= 1'b1;
                end
            end
            else if (rsp_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- src/rbp_checker.sv -----
`timescale 1ns / 1ps

module rbp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input rbp_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == rbp_pkg::ST_EMPTY |->
            rsp.free_count == '0 && rsp.use_count == '0 && rsp.result_id == '0)
        else $error("empty pool reported with free buffers");

    a_returned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.returned_to_pool |->
            rsp.status == rbp_pkg::ST_OK && rsp.use_count == '0 &&
            rsp.free_count != '0)
        else $error("buffer returned with nonzero count");

    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == rbp_pkg::ST_HELD |->
            rsp.use_count != '0 && !rsp.returned_to_pool)
        else $error("still referenced with zero count");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.free_count <= rbp_pkg::POOL_SIZE)
        else $error("free count beyond pool size");

endmodule

bind refcounted_buffer_pool rbp_checker u_rbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
